// ===== design/ulmf_pkg.sv =====
// Shared types and constants for the UART line message framer.
// No dependencies; used by the top level of the framer.
package ulmf_pkg;

    localparam int MSG_BYTES_DEF = 24;

    localparam logic [7:0] TERM_ZERO = 8'h00;
    localparam logic [7:0] TERM_NL   = 8'h0A;
    localparam logic [7:0] LOSS_MAX  = 8'hFF;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REPLAY = 3'b010,
        S_STATUS = 3'b100
    } t_state;

endpackage

// ===== design/ulmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ulmf_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 24,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/uart_line_message_framer.sv =====
// Top level of the UART line message framer: control, counters and output register.
// Depends on ulmf_pkg and ulmf_ram.
//
// The framer takes one received byte per transfer and answers it with a run of
// results that always closes with one status item. Bytes other than zero and
// newline are written to a message memory of MSG_BYTES entries. When a message
// ends (terminator, overrun or a byte arriving at a full store) and holds data,
// it is replayed from the memory, or dropped and counted as lost if the sink is
// full. A replay first issues the read of the single registered read port of
// the message memory, then moves each byte to the output register, at most
// MSG_BYTES of them, and ends with the status item; when nothing is replayed,
// only the status item is given. A stalled output holds the run back. The
// input stall stays high from the accepting transfer until the status item has
// been loaded into the output register, while a finished result may still wait
// there to be taken.
module uart_line_message_framer #(
    parameter int MSG_BYTES = ulmf_pkg::MSG_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_overrun,
    input  logic       i_sink_full,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_msg_byte,
    output logic       o_msg_end,
    output logic       o_run_last,
    output logic [7:0] o_loss_count
);

    localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int CW = $clog2(MSG_BYTES + 1);
    localparam logic [CW-1:0] FILL_MAX = CW'(MSG_BYTES);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    ulmf_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [7:0]    r_lost, n_lost;
    logic [CW-1:0] r_deliver, n_deliver;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_ld_idx, n_ld_idx;
    logic          r_pend, n_pend;

    logic          r_ovalid, n_ovalid;
    logic          r_okind, n_okind;
    logic [7:0]    r_obyte, n_obyte;
    logic          r_oend, n_oend;
    logic          r_olast, n_olast;
    logic [7:0]    r_oloss, n_oloss;

    logic          accept, out_free, load, issue;
    logic          is_term, store_full, do_store, finish, fin_nonempty, sink_drop;
    logic [CW-1:0] fill_new;
    logic [1:0]    loss_inc;
    logic [8:0]    loss_sum;
    logic          we;
    logic [7:0]    rdata;

    assign accept   = i_in_valid && (r_state == ulmf_pkg::S_IDLE);
    assign out_free = !r_ovalid || !i_out_stall;

    // Loss and store bookkeeping for the byte being taken in.
    assign is_term      = (i_rx_byte == ulmf_pkg::TERM_ZERO) ||
                          (i_rx_byte == ulmf_pkg::TERM_NL);
    assign store_full   = !is_term && (r_fill >= FILL_MAX);
    assign do_store     = !is_term && !store_full;
    assign fill_new     = do_store ? (r_fill + CNT_ONE) : r_fill;
    assign finish       = i_overrun || is_term || store_full;
    assign fin_nonempty = finish && (fill_new != '0);
    assign sink_drop    = fin_nonempty && i_sink_full;
    assign loss_inc     = 2'(i_overrun) + 2'(store_full) + 2'(sink_drop);
    assign loss_sum     = {1'b0, r_lost} + {7'd0, loss_inc};

    assign we    = accept && do_store;
    // A byte is moved from the read register to the output register, and the
    // next read is issued in the same cycle, so replay runs at one byte a cycle while the output is not stalled.
    assign load  = (r_state == ulmf_pkg::S_REPLAY) && r_pend && out_free;
    assign issue = (r_state == ulmf_pkg::S_REPLAY) && (r_rd_idx < r_deliver) &&
                   (!r_pend || load);

    ulmf_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_lost    = r_lost;
        n_deliver = r_deliver;
        n_rd_idx  = r_rd_idx;
        n_ld_idx  = r_ld_idx;
        n_pend    = r_pend;
        n_ovalid  = r_ovalid && i_out_stall;
        n_okind   = r_okind;
        n_obyte   = r_obyte;
        n_oend    = r_oend;
        n_olast   = r_olast;
        n_oloss   = r_oloss;

        unique case (r_state)
            ulmf_pkg::S_IDLE: begin
                if (accept) begin
                    n_fill   = fin_nonempty ? '0 : fill_new;
                    n_lost   = loss_sum[8] ? ulmf_pkg::LOSS_MAX : loss_sum[7:0];
                    n_rd_idx = '0;
                    n_ld_idx = '0;
                    n_pend   = 1'b0;
                    if (fin_nonempty && !i_sink_full) begin
                        n_deliver = fill_new;
                        n_state   = ulmf_pkg::S_REPLAY;
                    end else begin
                        n_deliver = '0;
                        n_state   = ulmf_pkg::S_STATUS;
                    end
                end
            end
            ulmf_pkg::S_REPLAY: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + CNT_ONE;
                end
                if (load) begin
                    n_ovalid = 1'b1;
                    n_okind  = ulmf_pkg::KIND_BYTE;
                    n_obyte  = rdata;
                    n_oend   = ((r_ld_idx + CNT_ONE) == r_deliver);
                    n_olast  = 1'b0;
                    n_oloss  = r_lost;
                    n_ld_idx = r_ld_idx + CNT_ONE;
                    if ((r_ld_idx + CNT_ONE) == r_deliver) begin
                        n_state = ulmf_pkg::S_STATUS;
                    end
                end
                n_pend = issue || (r_pend && !load);
            end
            ulmf_pkg::S_STATUS: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = ulmf_pkg::KIND_STATUS;
                    n_obyte  = '0;
                    n_oend   = 1'b0;
                    n_olast  = 1'b1;
                    n_oloss  = r_lost;
                    n_state  = ulmf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ulmf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ulmf_pkg::S_IDLE;
            r_fill    <= '0;
            r_lost    <= '0;
            r_deliver <= '0;
            r_rd_idx  <= '0;
            r_ld_idx  <= '0;
            r_pend    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_lost    <= n_lost;
            r_deliver <= n_deliver;
            r_rd_idx  <= n_rd_idx;
            r_ld_idx  <= n_ld_idx;
            r_pend    <= n_pend;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_okind <= n_okind;
        r_obyte <= n_obyte;
        r_oend  <= n_oend;
        r_olast <= n_olast;
        r_oloss <= n_oloss;
    end

    assign o_in_stall   = (r_state != ulmf_pkg::S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_kind       = r_okind;
    assign o_msg_byte   = r_obyte;
    assign o_msg_end    = r_oend;
    assign o_run_last   = r_olast;
    assign o_loss_count = r_oloss;

    // No replayed byte may be left in the read register once the run is over.
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ulmf_pkg::S_IDLE) |-> !r_pend)
        else $error("read data still pending while idle");

    a_ld_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ld_idx <= r_deliver) && (r_rd_idx <= r_deliver))
        else $error("replay index ran past the message length");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_rd_idx < FILL_MAX))
        else $error("memory read beyond the message store");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_okind == ulmf_pkg::KIND_STATUS)) |->
            (r_olast && !r_oend && (r_obyte == '0)))
        else $error("malformed status item");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count beyond the store size");

endmodule
